[rtl/core/arps_pkg.sv]
`default_nettype none
package arps_pkg;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic SEL_BASE = 1'b0;
  localparam logic SEL_TEST = 1'b1;

  localparam logic KIND_COMPUTE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  localparam logic [1:0] CFG_ROW_COUNT  = 2'd0;
  localparam logic [1:0] CFG_BASE_WIDTH = 2'd1;
  localparam logic [1:0] CFG_TEST_WIDTH = 2'd2;

  localparam logic [6:0]  ROW_COUNT_RESET = 7'd64;
  localparam logic [10:0] WIDTH_RESET     = 11'd1024;

  localparam logic [7:0] GAP_SYMBOL = 8'd45;
  localparam logic [5:0] SCORE_MAX  = 6'd63;

  typedef struct packed {
    logic [1:0] operation;
    logic       alignment_select;
    logic [5:0] row;
    logic [9:0] column;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic       response_kind;
    logic [5:0] score;
    logic       out_of_range;
  } out_item_t;

  typedef struct packed {
    logic base_we;
    logic test_we;
  } res_we_t;

  typedef struct packed {
    logic map_we;
    logic score_we;
  } tbl_we_t;

endpackage
`default_nettype wire

[rtl/core/arps_cells.sv]
`default_nettype none
// Residue/gap bit stores of the base and test alignments.
module arps_cells #(
  parameter int AW = 16
) (
  input  wire               clk_i,
  input  arps_pkg::res_we_t we_i,
  input  wire  [AW-1:0]     waddr_i,
  input  wire               wbit_i,
  input  wire  [AW-1:0]     base_raddr_i,
  input  wire  [AW-1:0]     test_raddr_i,
  output logic              base_bit_o,
  output logic              test_bit_o
);

  logic base_mem [2**AW];
  logic test_mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i.base_we) begin
      base_mem[waddr_i] <= wbit_i;
    end
    base_bit_o <= base_mem[base_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.test_we) begin
      test_mem[waddr_i] <= wbit_i;
    end
    test_bit_o <= test_mem[test_raddr_i];
  end

endmodule
`default_nettype wire

[rtl/core/arps_tables.sv]
`default_nettype none
// Test-to-base map store (valid bit plus base column) and score store.
module arps_tables #(
  parameter int AW = 16,
  parameter int MW = 11,
  parameter int SW = 6
) (
  input  wire               clk_i,
  input  arps_pkg::tbl_we_t we_i,
  input  wire  [AW-1:0]     map_waddr_i,
  input  wire  [MW-1:0]     map_wdata_i,
  input  wire  [AW-1:0]     map_raddr_i,
  output logic [MW-1:0]     map_rdata_o,
  input  wire  [AW-1:0]     sc_waddr_i,
  input  wire  [SW-1:0]     sc_wdata_i,
  input  wire  [AW-1:0]     sc_raddr_i,
  output logic [SW-1:0]     sc_rdata_o
);

  logic [MW-1:0] map_mem [2**AW];
  logic [SW-1:0] sc_mem  [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i.map_we) begin
      map_mem[map_waddr_i] <= map_wdata_i;
    end
    map_rdata_o <= map_mem[map_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.score_we) begin
      sc_mem[sc_waddr_i] <= sc_wdata_i;
    end
    sc_rdata_o <= sc_mem[sc_raddr_i];
  end

endmodule
`default_nettype wire

[rtl/core/alignment_residue_pair_scorer_core.sv]
`default_nettype none
// Residue pair support scorer. Two alignments of the same sequences, a base
// and a test, are loaded one symbol per item; each cell keeps one bit that
// tells residue from gap ('-'). A load item is written straight into the
// cell stores and gives no result. A read item passes through ST_RD_DATA
// and returns the score of one base cell; a read whose row or column lies
// outside the configured size goes straight to ST_RESP and flags
// out_of_range. A compute item first sweeps the whole score and map stores
// once (sizes rounded up to powers of two), then pairs residues row by row,
// each visited cell pair passing through ST_MAP_RD and ST_MAP_EV, then
// walks every test column: for each mapped row it streams all rows of that
// column through the map store and updates the score store with one
// read-modify-write, while an unmapped row only passes through ST_SC_J and
// ST_SC_JD. The single read port of the map store sets the compute time.
// After reset the same sweep runs once before the first item is taken;
// configuration writes are accepted at any time but must only be made while
// the block is idle.
module alignment_residue_pair_scorer_core #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 1024
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  arps_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output arps_pkg::out_item_t out_item_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [1:0]          cfg_index_i,
  input  wire  [10:0]         cfg_data_i
);

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int RC_W   = $clog2(MAX_ROWS + 1);
  localparam int CC_W   = $clog2(MAX_COLS + 1);
  localparam int SC_W   = $clog2(MAX_ROWS);
  localparam int MAP_W  = COL_W + 1;

  // One-hot sequencer states.
  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_RD_DATA = 11'b000_0000_0010,
    ST_CLR     = 11'b000_0000_0100,
    ST_MAP_RD  = 11'b000_0000_1000,
    ST_MAP_EV  = 11'b000_0001_0000,
    ST_SC_J    = 11'b000_0010_0000,
    ST_SC_JD   = 11'b000_0100_0000,
    ST_SC_CNT  = 11'b000_1000_0000,
    ST_SC_SRD  = 11'b001_0000_0000,
    ST_SC_SWR  = 11'b010_0000_0000,
    ST_RESP    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [6:0]  row_count_q, row_count_d;
  logic [10:0] base_width_q, base_width_d;
  logic [10:0] test_width_q, test_width_d;

  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              clr_cmp_q, clr_cmp_d;
  logic [RC_W-1:0]   j_q, j_d;
  logic [RC_W-1:0]   r_q, r_d;
  logic [ROW_W-1:0]  pr_q, pr_d;
  logic              pend_q, pend_d;
  logic [CC_W-1:0]   bi_q, bi_d;
  logic [CC_W-1:0]   ti_q, ti_d;
  logic [CC_W-1:0]   t_q, t_d;
  logic [COL_W-1:0]  x0_q, x0_d;
  logic [SC_W-1:0]   cnt_q, cnt_d;

  arps_pkg::out_item_t res_q, res_d;
  arps_pkg::out_item_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [RC_W-1:0] rows_eff;
  logic [CC_W-1:0] bw_eff;
  logic [CC_W-1:0] tw_eff;

  logic accept;
  logic load_ok;
  logic read_oor;

  arps_pkg::res_we_t res_we;
  logic [ADDR_W-1:0] load_addr;
  logic              base_bit, test_bit;

  arps_pkg::tbl_we_t tbl_we;
  logic [ADDR_W-1:0] map_waddr, map_raddr, sc_waddr, sc_raddr;
  logic [MAP_W-1:0]  map_wdata, map_rdata;
  logic [SC_W-1:0]   sc_wdata, sc_rdata;

  logic b_ok, t_ok, b_gap, t_gap;

  // Sizes saturate to the store dimensions.
  assign rows_eff = (32'(row_count_q) > MAX_ROWS) ? RC_W'(MAX_ROWS) : RC_W'(row_count_q);
  assign bw_eff   = (32'(base_width_q) > MAX_COLS) ? CC_W'(MAX_COLS) : CC_W'(base_width_q);
  assign tw_eff   = (32'(test_width_q) > MAX_COLS) ? CC_W'(MAX_COLS) : CC_W'(test_width_q);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign load_ok  = (32'(in_item_i.row) < MAX_ROWS) && (32'(in_item_i.column) < MAX_COLS);
  assign read_oor = (32'(in_item_i.row) >= 32'(rows_eff))
                 || (32'(in_item_i.column) >= 32'(bw_eff));

  assign load_addr = {ROW_W'(in_item_i.row), COL_W'(in_item_i.column)};

  // Load path writes the residue stores straight from the input item.
  always_comb begin
    res_we.base_we = accept && (in_item_i.operation == arps_pkg::OP_LOAD) && load_ok
                     && (in_item_i.alignment_select == arps_pkg::SEL_BASE);
    res_we.test_we = accept && (in_item_i.operation == arps_pkg::OP_LOAD) && load_ok
                     && (in_item_i.alignment_select == arps_pkg::SEL_TEST);
  end

  arps_cells #(
    .AW(ADDR_W)
  ) u_cells (
    .clk_i        (clk_i),
    .we_i         (res_we),
    .waddr_i      (load_addr),
    .wbit_i       (in_item_i.symbol != arps_pkg::GAP_SYMBOL),
    .base_raddr_i ({ROW_W'(j_q), COL_W'(bi_q)}),
    .test_raddr_i ({ROW_W'(j_q), COL_W'(ti_q)}),
    .base_bit_o   (base_bit),
    .test_bit_o   (test_bit)
  );

  // Pairing decision for the cell pair read in the previous cycle.
  assign b_ok  = bi_q < bw_eff;
  assign t_ok  = ti_q < tw_eff;
  assign b_gap = b_ok && !base_bit;
  assign t_gap = t_ok && !test_bit;

  // Store port steering. The sequencer never has a write and a read of the
  // same entry in flight, so no forwarding is needed.
  always_comb begin
    tbl_we.map_we   = (state_q == ST_CLR)
                   || ((state_q == ST_MAP_EV) && !b_gap && !t_gap && b_ok && t_ok);
    tbl_we.score_we = (state_q == ST_CLR) || (state_q == ST_SC_SWR);

    map_waddr = (state_q == ST_CLR) ? clr_q : {ROW_W'(j_q), COL_W'(ti_q)};
    map_wdata = (state_q == ST_CLR) ? '0 : {1'b1, COL_W'(bi_q)};
    map_raddr = (state_q == ST_SC_CNT) ? {ROW_W'(r_q), COL_W'(t_q)}
                                       : {ROW_W'(j_q), COL_W'(t_q)};

    sc_waddr = (state_q == ST_CLR) ? clr_q : {ROW_W'(j_q), x0_q};
    sc_wdata = (state_q == ST_CLR) ? '0 : SC_W'(sc_rdata + cnt_q);
    sc_raddr = (state_q == ST_IDLE) ? load_addr : {ROW_W'(j_q), x0_q};
  end

  arps_tables #(
    .AW(ADDR_W),
    .MW(MAP_W),
    .SW(SC_W)
  ) u_tables (
    .clk_i       (clk_i),
    .we_i        (tbl_we),
    .map_waddr_i (map_waddr),
    .map_wdata_i (map_wdata),
    .map_raddr_i (map_raddr),
    .map_rdata_o (map_rdata),
    .sc_waddr_i  (sc_waddr),
    .sc_wdata_i  (sc_wdata),
    .sc_raddr_i  (sc_raddr),
    .sc_rdata_o  (sc_rdata)
  );

  // Configuration writes; indexes beyond the list are dropped.
  always_comb begin
    row_count_d  = row_count_q;
    base_width_d = base_width_q;
    test_width_d = test_width_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        arps_pkg::CFG_ROW_COUNT:  row_count_d  = cfg_data_i[6:0];
        arps_pkg::CFG_BASE_WIDTH: base_width_d = cfg_data_i;
        arps_pkg::CFG_TEST_WIDTH: test_width_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Main sequencer.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    clr_cmp_d = clr_cmp_q;
    j_d       = j_q;
    r_d       = r_q;
    pr_d      = pr_q;
    pend_d    = pend_q;
    bi_d      = bi_q;
    ti_d      = ti_q;
    t_d       = t_q;
    x0_d      = x0_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    out_d     = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.operation)
            arps_pkg::OP_COMPUTE: begin
              clr_d     = '0;
              clr_cmp_d = 1'b1;
              state_d   = ST_CLR;
            end
            arps_pkg::OP_READ: begin
              if (read_oor) begin
                res_d.response_kind = arps_pkg::KIND_READ;
                res_d.score         = '0;
                res_d.out_of_range  = 1'b1;
                state_d             = ST_RESP;
              end else begin
                state_d = ST_RD_DATA;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD_DATA: begin
        res_d.response_kind = arps_pkg::KIND_READ;
        res_d.score         = (32'(sc_rdata) > 32'(arps_pkg::SCORE_MAX))
                              ? arps_pkg::SCORE_MAX : 6'(sc_rdata);
        res_d.out_of_range  = 1'b0;
        state_d             = ST_RESP;
      end
      ST_CLR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          if (clr_cmp_q) begin
            j_d     = '0;
            bi_d    = '0;
            ti_d    = '0;
            state_d = ST_MAP_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MAP_RD: begin
        if (j_q >= rows_eff) begin
          j_d     = '0;
          t_d     = '0;
          state_d = ST_SC_J;
        end else begin
          state_d = ST_MAP_EV;
        end
      end
      ST_MAP_EV: begin
        state_d = ST_MAP_RD;
        if (b_gap || t_gap) begin
          if (b_gap) begin
            bi_d = bi_q + 1'b1;
          end
          if (t_gap) begin
            ti_d = ti_q + 1'b1;
          end
        end else if (!b_ok || !t_ok) begin
          j_d  = j_q + 1'b1;
          bi_d = '0;
          ti_d = '0;
        end else begin
          bi_d = bi_q + 1'b1;
          ti_d = ti_q + 1'b1;
        end
      end
      ST_SC_J: begin
        if (t_q >= tw_eff) begin
          res_d.response_kind = arps_pkg::KIND_COMPUTE;
          res_d.score         = '0;
          res_d.out_of_range  = 1'b0;
          state_d             = ST_RESP;
        end else if (j_q >= rows_eff) begin
          j_d = '0;
          t_d = t_q + 1'b1;
        end else begin
          state_d = ST_SC_JD;
        end
      end
      ST_SC_JD: begin
        if (!map_rdata[MAP_W-1]) begin
          j_d     = j_q + 1'b1;
          state_d = ST_SC_J;
        end else begin
          x0_d    = map_rdata[COL_W-1:0];
          r_d     = '0;
          pend_d  = 1'b0;
          cnt_d   = '0;
          state_d = ST_SC_CNT;
        end
      end
      ST_SC_CNT: begin
        // Rows of the column stream through the map read port, one a cycle.
        if (pend_q && (pr_q != ROW_W'(j_q)) && map_rdata[MAP_W-1]
            && (map_rdata[COL_W-1:0] == x0_q)) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (r_q < rows_eff) begin
          pend_d = 1'b1;
          pr_d   = ROW_W'(r_q);
          r_d    = r_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_SC_SRD;
          end
        end
      end
      ST_SC_SRD: begin
        state_d = ST_SC_SWR;
      end
      ST_SC_SWR: begin
        j_d     = j_q + 1'b1;
        state_d = ST_SC_J;
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      clr_q        <= '0;
      clr_cmp_q    <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      row_count_q  <= arps_pkg::ROW_COUNT_RESET;
      base_width_q <= arps_pkg::WIDTH_RESET;
      test_width_q <= arps_pkg::WIDTH_RESET;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      clr_cmp_q    <= clr_cmp_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      row_count_q  <= row_count_d;
      base_width_q <= base_width_d;
      test_width_q <= test_width_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    r_q   <= r_d;
    pr_q  <= pr_d;
    bi_q  <= bi_d;
    ti_q  <= ti_d;
    t_q   <= t_d;
    x0_q  <= x0_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

[rtl/core/arps_checker.sv]
`default_nettype none
module arps_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_stall_o,
  input arps_pkg::in_item_t  in_item_i,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input arps_pkg::out_item_t out_item_o
);

  // A held result must not change while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // An out-of-range read never carries a score.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.out_of_range |-> out_item_o.score == 6'd0)
    else $error("out-of-range read with nonzero score");

  // A compute answer carries no score and no range flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.response_kind == arps_pkg::KIND_COMPUTE)
    |-> out_item_o.score == 6'd0 && !out_item_o.out_of_range)
    else $error("compute answer with payload");

  // A read or compute item blocks the input until its answer is formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && ((in_item_i.operation == arps_pkg::OP_READ)
    || (in_item_i.operation == arps_pkg::OP_COMPUTE)) |=> in_stall_o)
    else $error("input not stalled after read or compute");

endmodule

bind alignment_residue_pair_scorer_core arps_checker u_arps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire
